FILE: rtl/core/cpst_pkg.sv
// ---------------------------------------------------------------------------
// cpst_pkg: shared constants and types for the cone point side test
// Register indexes, reset values, side codes and pipeline sideband types.
// ---------------------------------------------------------------------------
package cpst_pkg;

    // configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // fixed field widths
    localparam int APEX_W   = 32;
    localparam int AXIS_W   = 32;
    localparam int ANG_W    = 31;
    localparam int THR_W    = 32;
    localparam int SIDE_W   = 2;
    localparam int MUL_LIMB = 32;

    localparam int DEF_COORD_WIDTH = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_APEX_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_APEX_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_APEX_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Z   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_HALF = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL      = 3'd7;

    // reset values
    localparam logic [AXIS_W-1:0] RST_AXIS_X = 32'd1073741824;
    localparam logic [ANG_W-1:0]  RST_COS    = 31'd1073741824;
    localparam logic [ANG_W-1:0]  RST_TOL    = 31'd1074;

    // result codes
    localparam logic [SIDE_W-1:0] SIDE_SURF = 2'd0;
    localparam logic [SIDE_W-1:0] SIDE_POS  = 2'd1;
    localparam logic [SIDE_W-1:0] SIDE_NEG  = 2'd2;

    // sideband flags travelling with a word through the back half
    typedef struct packed {
        logic zero;    // point sits on the apex
        logic lo_neg;  // lower threshold below zero
    } t_side_flags;

endpackage

FILE: rtl/core/cpst_mul.sv
// ---------------------------------------------------------------------------
// cpst_mul: three-stage unsigned limb multiplier
// Limb partial products, then row sums, then the final sum; one enable per
// register level so the stage can hold under a stall.
// ---------------------------------------------------------------------------
module cpst_mul import cpst_pkg::*; #(
    parameter int A_W = 32,
    parameter int B_W = 32
) (
    input  logic               i_clk,
    input  logic [2:0]         i_en,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic [A_W+B_W-1:0] o_p
);

    localparam int L  = MUL_LIMB;
    localparam int NA = (A_W + L - 1) / L;
    localparam int NB = (B_W + L - 1) / L;
    localparam int RW = (NB + 1) * L;
    localparam int FW = (NA + NB + 1) * L;

    logic [NA*L-1:0]    a_pad;
    logic [NB*L-1:0]    b_pad;
    logic [2*L-1:0]     r_pp  [NA][NB];
    logic [RW-1:0]      r_row [NA];
    logic [RW-1:0]      n_row [NA];
    logic [FW-1:0]      n_sum;
    logic [A_W+B_W-1:0] r_p;

    assign a_pad = (NA*L)'(i_a);
    assign b_pad = (NB*L)'(i_b);

    // level 1: limb products
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= (2*L)'(a_pad[i*L +: L]) * (2*L)'(b_pad[j*L +: L]);
                end
            end
        end
    end

    // level 2: one row per limb of a
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                n_row[i] = n_row[i] + (RW'(r_pp[i][j]) << (j*L));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_row <= n_row;
        end
    end

    // level 3: rows together
    always_comb begin
        n_sum = '0;
        for (int i = 0; i < NA; i++) begin
            n_sum = n_sum + (FW'(r_row[i]) << (i*L));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_p <= n_sum[A_W+B_W-1:0];
        end
    end

    assign o_p = r_p;

endmodule

FILE: rtl/core/cpst_decide.sv
// ---------------------------------------------------------------------------
// cpst_decide: threshold compares and result register
// Compares (d.axis)^2 with thr^2 * (d.d) for the three thresholds and forms
// the side code and the on-surface flag.
// ---------------------------------------------------------------------------
module cpst_decide import cpst_pkg::*; #(
    parameter int P2_W = 134,
    parameter int Q_W  = 132
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [P2_W-1:0]   i_p2,
    input  logic [Q_W-1:0]    i_q_lo,
    input  logic [Q_W-1:0]    i_q_mid,
    input  logic [Q_W-1:0]    i_q_hi,
    input  t_side_flags       i_flags,
    output logic [SIDE_W-1:0] o_side_code,
    output logic              o_on_surface
);

    localparam int CW = (P2_W > Q_W) ? P2_W : Q_W;

    logic [CW-1:0]     p2;
    logic [CW-1:0]     q_lo;
    logic [CW-1:0]     q_mid;
    logic [CW-1:0]     q_hi;
    logic              lo_gt;
    logic              lo_ge;
    logic              hi_lt;
    logic              hi_le;
    logic              mid_gt;
    logic [SIDE_W-1:0] n_side;
    logic              n_on;
    logic [SIDE_W-1:0] r_side;
    logic              r_on;

    assign p2    = CW'(i_p2);
    assign q_lo  = CW'(i_q_lo);
    assign q_mid = CW'(i_q_mid);
    assign q_hi  = CW'(i_q_hi);

    // a negative lower threshold is always exceeded
    assign lo_gt  = i_flags.lo_neg | (p2 > q_lo);
    assign lo_ge  = i_flags.lo_neg | (p2 >= q_lo);
    assign hi_lt  = p2 < q_hi;
    assign hi_le  = p2 <= q_hi;
    assign mid_gt = p2 > q_mid;

    always_comb begin
        if (i_flags.zero) begin
            n_side = SIDE_NEG;
            n_on   = 1'b1;
        end else begin
            if (lo_gt && hi_lt) begin
                n_side = SIDE_SURF;
            end else if (mid_gt) begin
                n_side = SIDE_POS;
            end else begin
                n_side = SIDE_NEG;
            end
            n_on = lo_ge & hi_le;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= n_side;
            r_on   <= n_on;
        end
    end

    assign o_side_code  = r_side;
    assign o_on_surface = r_on;

endmodule

FILE: rtl/core/cone_point_side_test_core.sv
// ---------------------------------------------------------------------------
// cone_point_side_test_core: classify a point against a double cone
// Input channel: one word per point (x, y, z signed Q16.16) on i_valid /
// o_ready. Output channel: side code and on-surface flag on o_valid /
// i_ready. Configuration: apex, axis, cosine and tolerance written through
// i_cfg_we / i_cfg_idx / i_cfg_data; the user must write them only while no
// word is in flight, which the block does not enforce. Stages: difference,
// three multiply levels for d.d, d.axis and thr^2, sum, three multiply levels
// for (d.axis)^2 and thr^2 * d.d, compare and result register. Throughput:
// one word per cycle while i_ready is high; every stage has its own enable,
// so bubbles close up and a new word is taken while a finished result waits.
// Reset: synchronous, active low; clears the valid bits and loads the
// default cone (apex at origin, axis +x, cosine 1.0, tolerance 1074).
// Receiver stall: the last stage holds its result; earlier stages keep
// filling until each holds a word, then o_ready drops.
// A point on the apex gives side code negative with on_surface set.
// ---------------------------------------------------------------------------
module cone_point_side_test_core import cpst_pkg::*; #(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [COORD_WIDTH-1:0] i_point_x,
    input  logic [COORD_WIDTH-1:0] i_point_y,
    input  logic [COORD_WIDTH-1:0] i_point_z,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [SIDE_W-1:0]      o_side_code,
    output logic                   o_on_surface,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int DW   = COORD_WIDTH + 1;
    localparam int SQW  = 2 * DW;
    localparam int SW   = SQW + 2;
    localparam int PRW  = DW + AXIS_W;
    localparam int PSW  = PRW + 3;
    localparam int PW   = PRW + 2;
    localparam int TSW  = 2 * THR_W;
    localparam int P2W  = 2 * PW;
    localparam int QW   = TSW + SW;
    localparam int NLVL = 9;

    // configuration registers
    logic [APEX_W-1:0] r_apex [3];
    logic [AXIS_W-1:0] r_axis [3];
    logic [ANG_W-1:0]  r_cos;
    logic [ANG_W-1:0]  r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apex[0] <= '0;
            r_apex[1] <= '0;
            r_apex[2] <= '0;
            r_axis[0] <= RST_AXIS_X;
            r_axis[1] <= '0;
            r_axis[2] <= '0;
            r_cos     <= RST_COS;
            r_tol     <= RST_TOL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_APEX_X:   r_apex[0] <= i_cfg_data;
                CFG_APEX_Y:   r_apex[1] <= i_cfg_data;
                CFG_APEX_Z:   r_apex[2] <= i_cfg_data;
                CFG_AXIS_X:   r_axis[0] <= i_cfg_data;
                CFG_AXIS_Y:   r_axis[1] <= i_cfg_data;
                CFG_AXIS_Z:   r_axis[2] <= i_cfg_data;
                CFG_COS_HALF: r_cos     <= i_cfg_data[ANG_W-1:0];
                CFG_TOL:      r_tol     <= i_cfg_data[ANG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // stage enables: a stage loads when empty or when the next one moves
    logic [NLVL:0]   en;
    logic [NLVL-1:0] r_vld;

    always_comb begin
        en[NLVL] = i_ready;
        for (int k = NLVL - 1; k >= 0; k--) begin
            en[k] = ~r_vld[k] | en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NLVL; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[NLVL-1];

    // level 0: differences, magnitudes, thresholds
    logic [COORD_WIDTH-1:0] pt [3];
    logic [DW-1:0]          apex_e [3];
    logic [DW-1:0]          d [3];

    assign pt[0] = i_point_x;
    assign pt[1] = i_point_y;
    assign pt[2] = i_point_z;

    // apex read as a coordinate: sign taken from bit COORD_WIDTH-1 when it lies
    // inside the register, otherwise the register is zero-extended
    generate
        if (COORD_WIDTH <= APEX_W) begin : g_apex_sext
            for (genvar k = 0; k < 3; k++) begin : g_ax
                assign apex_e[k] = {r_apex[k][COORD_WIDTH-1], r_apex[k][COORD_WIDTH-1:0]};
            end
        end else begin : g_apex_zext
            for (genvar k = 0; k < 3; k++) begin : g_ax
                assign apex_e[k] = DW'(r_apex[k]);
            end
        end
    endgenerate

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d[k] = {pt[k][COORD_WIDTH-1], pt[k]} - apex_e[k];
        end
    end

    logic [DW-1:0]     r_dmag [3];
    logic [2:0]        r_psg0;
    logic [AXIS_W-1:0] r_amag [3];
    logic [THR_W-1:0]  r_thr  [3];
    logic              r_ln0;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int k = 0; k < 3; k++) begin
                r_dmag[k] <= d[k][DW-1] ? (DW'(0) - d[k]) : d[k];
                r_amag[k] <= r_axis[k][AXIS_W-1] ? (AXIS_W'(0) - r_axis[k]) : r_axis[k];
                r_psg0[k] <= d[k][DW-1] ^ r_axis[k][AXIS_W-1];
            end
            r_thr[0] <= THR_W'(r_cos) - THR_W'(r_tol);
            r_thr[1] <= THR_W'(r_cos);
            r_thr[2] <= THR_W'(r_cos) + THR_W'(r_tol);
            r_ln0    <= r_tol > r_cos;
        end
    end

    // levels 1 to 3: squares, axial products, threshold squares
    logic [SQW-1:0] sq  [3];
    logic [PRW-1:0] pr  [3];
    logic [TSW-1:0] th2 [3];

    generate
        for (genvar k = 0; k < 3; k++) begin : g_mul_a
            cpst_mul #(.A_W(DW), .B_W(DW)) u_sq (
                .i_clk (i_clk),
                .i_en  (en[3:1]),
                .i_a   (r_dmag[k]),
                .i_b   (r_dmag[k]),
                .o_p   (sq[k])
            );
            cpst_mul #(.A_W(DW), .B_W(AXIS_W)) u_pr (
                .i_clk (i_clk),
                .i_en  (en[3:1]),
                .i_a   (r_dmag[k]),
                .i_b   (r_amag[k]),
                .o_p   (pr[k])
            );
            cpst_mul #(.A_W(THR_W), .B_W(THR_W)) u_th (
                .i_clk (i_clk),
                .i_en  (en[3:1]),
                .i_a   (r_thr[k]),
                .i_b   (r_thr[k]),
                .o_p   (th2[k])
            );
        end
    endgenerate

    logic [2:0] r_psg1, r_psg2, r_psg3;
    logic       r_ln1, r_ln2, r_ln3;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_psg1 <= r_psg0;
            r_ln1  <= r_ln0;
        end
        if (en[2]) begin
            r_psg2 <= r_psg1;
            r_ln2  <= r_ln1;
        end
        if (en[3]) begin
            r_psg3 <= r_psg2;
            r_ln3  <= r_ln2;
        end
    end

    // level 4: d.d and |d.axis|
    logic [SW-1:0]         n_s;
    logic signed [PSW-1:0] n_psum;
    logic [PSW-1:0]        n_pabs;

    always_comb begin
        n_s    = SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
        n_psum = '0;
        for (int k = 0; k < 3; k++) begin
            n_psum = r_psg3[k] ? (n_psum - $signed(PSW'(pr[k])))
                               : (n_psum + $signed(PSW'(pr[k])));
        end
        n_pabs = n_psum[PSW-1] ? PSW'(-n_psum) : PSW'(n_psum);
    end

    logic [SW-1:0]  r_s4;
    logic [PW-1:0]  r_pmag4;
    logic [TSW-1:0] r_th2_4 [3];
    t_side_flags    r_fl4, r_fl5, r_fl6, r_fl7;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_s4         <= n_s;
            r_pmag4      <= n_pabs[PW-1:0];
            r_th2_4      <= th2;
            r_fl4.zero   <= n_s == '0;
            r_fl4.lo_neg <= r_ln3;
        end
        if (en[5]) begin
            r_fl5 <= r_fl4;
        end
        if (en[6]) begin
            r_fl6 <= r_fl5;
        end
        if (en[7]) begin
            r_fl7 <= r_fl6;
        end
    end

    // levels 5 to 7: (d.axis)^2 and thr^2 * d.d
    logic [P2W-1:0] p2;
    logic [QW-1:0]  q [3];

    cpst_mul #(.A_W(PW), .B_W(PW)) u_p2 (
        .i_clk (i_clk),
        .i_en  (en[7:5]),
        .i_a   (r_pmag4),
        .i_b   (r_pmag4),
        .o_p   (p2)
    );

    generate
        for (genvar k = 0; k < 3; k++) begin : g_mul_b
            cpst_mul #(.A_W(TSW), .B_W(SW)) u_q (
                .i_clk (i_clk),
                .i_en  (en[7:5]),
                .i_a   (r_th2_4[k]),
                .i_b   (r_s4),
                .o_p   (q[k])
            );
        end
    endgenerate

    // level 8: compare and result
    cpst_decide #(.P2_W(P2W), .Q_W(QW)) u_decide (
        .i_clk        (i_clk),
        .i_en         (en[8]),
        .i_p2         (p2),
        .i_q_lo       (q[0]),
        .i_q_mid      (q[1]),
        .i_q_hi       (q[2]),
        .i_flags      (r_fl7),
        .o_side_code  (o_side_code),
        .o_on_surface (o_on_surface)
    );

    // checks
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("empty output stage but input not ready");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_vld[0])
        else $error("accepted word missing from first stage");

    a_no_code3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_side_code == SIDE_SURF || o_side_code == SIDE_POS ||
                     o_side_code == SIDE_NEG))
        else $error("unused side code delivered");

    a_surf_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_side_code == SIDE_SURF |-> o_on_surface)
        else $error("surface side code without on-surface flag");

endmodule

FILE: tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench: self-checking bench for cone_point_side_test_core
// Drives random and directed points against a series of cone settings,
// predicts side code and on-surface flag with wide integer arithmetic and
// checks every result word in order under random sender and receiver idling.
// ---------------------------------------------------------------------------
module testbench;
    import cpst_pkg::*;

    localparam int CW = 32;

    // cone geometry held by the predictor
    typedef struct {
        logic signed [31:0] apex [3];
        logic signed [31:0] axis [3];
        logic [30:0]        cosv;
        logic [30:0]        tol;
    } t_cone;

    typedef struct {
        logic [SIDE_W-1:0] side;
        logic              on;
    } t_class;

    // scoreboard: classifies accepted points, checks result words in order
    class side_scoreboard;
        t_cone  cone;
        t_class pending[$];
        int     errors;

        function new();
            cone.apex[0] = 0; cone.apex[1] = 0; cone.apex[2] = 0;
            cone.axis[0] = RST_AXIS_X; cone.axis[1] = 0; cone.axis[2] = 0;
            cone.cosv = RST_COS;
            cone.tol  = RST_TOL;
            errors = 0;
        endfunction

        // sign of e - thr/2^30 given p2 = (d.axis)^2 and s = d.d
        function int thr_cmp(logic signed [255:0] p2, logic signed [255:0] s,
                             logic signed [63:0] thr);
            logic signed [255:0] rhs;
            if (thr < 0) return 1;
            rhs = thr * thr * s;
            return (p2 > rhs) ? 1 : (p2 < rhs) ? -1 : 0;
        endfunction

        function void note_point(logic [CW-1:0] px, logic [CW-1:0] py,
                                 logic [CW-1:0] pz);
            logic signed [255:0] d [3];
            logic signed [255:0] s, p, p2;
            logic signed [63:0]  c, t;
            int lo, hi, mid;
            t_class r;
            d[0] = $signed(px) - $signed(cone.apex[0]);
            d[1] = $signed(py) - $signed(cone.apex[1]);
            d[2] = $signed(pz) - $signed(cone.apex[2]);
            s = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
            if (s == 0) begin
                r.side = SIDE_NEG;
                r.on   = 1'b1;
            end else begin
                p = d[0] * cone.axis[0] + d[1] * cone.axis[1] + d[2] * cone.axis[2];
                p2 = p * p;
                c = cone.cosv;
                t = cone.tol;
                lo  = thr_cmp(p2, s, c - t);
                hi  = thr_cmp(p2, s, c + t);
                mid = thr_cmp(p2, s, c);
                if (lo > 0 && hi < 0) r.side = SIDE_SURF;
                else r.side = (mid > 0) ? SIDE_POS : SIDE_NEG;
                r.on = (lo >= 0 && hi <= 0);
            end
            pending.push_back(r);
        endfunction

        function void check_word(logic [SIDE_W-1:0] side, logic on);
            t_class e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word side=%0d on=%0b", $time, side, on);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (side !== e.side) begin
                $display("%0t: side_code expected %0d actual %0d", $time, e.side, side);
                errors++;
            end
            if (on !== e.on) begin
                $display("%0t: on_surface expected %0b actual %0b", $time, e.on, on);
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [CW-1:0]         pt_x = '0, pt_y = '0, pt_z = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [SIDE_W-1:0]     side_code;
    logic                  on_surface;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = CFG_APEX_X;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    side_scoreboard sb = new();
    bit hold_off = 1'b0;
    int burst_left = 0;

    always #6 clk = ~clk;

    cone_point_side_test_core #(.COORD_WIDTH(CW)) dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_point_x(pt_x), .i_point_y(pt_y), .i_point_z(pt_z),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_side_code(side_code), .o_on_surface(on_surface),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    // receiver: own stall pattern, plus a long hold-off on request
    always @(posedge clk) begin
        if (out_valid && out_ready) sb.check_word(side_code, on_surface);
        if (hold_off) out_ready <= 1'b0;
        else case ($urandom_range(0, 3))
            0: out_ready <= ($urandom_range(0, 4) == 0);
            default: out_ready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    // write one register at a clock edge, then drop the write enable and idle
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_APEX_X:   sb.cone.apex[0] = val;
            CFG_APEX_Y:   sb.cone.apex[1] = val;
            CFG_APEX_Z:   sb.cone.apex[2] = val;
            CFG_AXIS_X:   sb.cone.axis[0] = val;
            CFG_AXIS_Y:   sb.cone.axis[1] = val;
            CFG_AXIS_Z:   sb.cone.axis[2] = val;
            CFG_COS_HALF: sb.cone.cosv = val[30:0];
            default:      sb.cone.tol = val[30:0];
        endcase
        @(posedge clk);
    endtask

    // offer one word; bursts of random length with gaps between
    task automatic send_point(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_valid <= 1'b1;
        pt_x <= x; pt_y <= y; pt_z <= z;
        do @(posedge clk); while (!in_ready);
        sb.note_point(x, y, z);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 7) << 16;
            2: return -($urandom_range(0, 7) << 16);
            default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    // a point off the apex along axis x, with a small y offset and at times a random z
    task automatic near_point();
        logic [31:0] a;
        a = $urandom_range(1, 32'h0010_0000);
        send_point(sb.cone.apex[0] + ($urandom_range(0, 1) ? a : -a),
                   sb.cone.apex[1] + rnd_coord() / ($urandom_range(1, 64) * 256),
                   sb.cone.apex[2] + ($urandom_range(0, 3) == 0 ? $urandom : 0));
    endtask

    // random cone with unit-ish axis; cosine and tolerance spread wide
    task automatic random_cone();
        int k;
        k = $urandom_range(0, 2);
        cfg_write(CFG_APEX_X, rnd_coord());
        cfg_write(CFG_APEX_Y, rnd_coord());
        cfg_write(CFG_APEX_Z, rnd_coord());
        cfg_write(CFG_AXIS_X, k == 0 ? $urandom_range(0, 1 << 30) : 0);
        cfg_write(CFG_AXIS_Y, k == 1 ? -$urandom_range(0, 1 << 30) : $urandom_range(0, 1 << 20));
        cfg_write(CFG_AXIS_Z, k == 2 ? $urandom_range(0, 1 << 30)
                                     : $urandom_range(0, 1 << 31) - (1 << 30));
        cfg_write(CFG_COS_HALF, $urandom_range(0, 1 << 30));
        cfg_write(CFG_TOL, $urandom_range(0, 1) ? $urandom_range(0, 1 << 16)
                                                : $urandom_range(0, 1 << 30));
    endtask

    initial begin
        #200000000;
        $display("** cone_point_side_test_core: FAILED **");
        $finish;
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default cone: on axis, apex, exact cosine edge, extremes
        send_point(32'h0001_0000, 0, 0);
        send_point(0, 0, 0);
        send_point(32'h0001_0000, 32'h0000_0001, 0);
        send_point(0, 32'h0001_0000, 0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        // 45 degree cone, zero tolerance: boundary e == cos up to rounding of the cosine
        cfg_write(CFG_AXIS_X, 0);
        cfg_write(CFG_AXIS_Z, 32'h4000_0000);
        cfg_write(CFG_COS_HALF, 31'd759250125);
        cfg_write(CFG_TOL, 0);
        send_point(32'h0001_0000, 0, 32'h0001_0000);
        send_point(0, 0, 32'h0001_0000);
        send_point(32'h0001_0000, 0, 0);
        drain();
        // cosine 0, tolerance above cosine, tolerance exactly at distance
        cfg_write(CFG_COS_HALF, 0);
        cfg_write(CFG_TOL, 31'h4000_0000);
        send_point(32'h0001_0000, 0, 32'h0001_0000);
        send_point(0, 0, 32'h0001_0000);
        send_point(32'h0001_0000, 32'h0002_0000, 0);
        drain();
        // extreme apex and non-unit axis
        cfg_write(CFG_APEX_X, 32'h8000_0000);
        cfg_write(CFG_APEX_Y, 32'h7FFF_FFFF);
        cfg_write(CFG_APEX_Z, 32'hC000_0000);
        cfg_write(CFG_AXIS_X, 32'hC000_0000);
        cfg_write(CFG_AXIS_Y, 32'h4000_0000);
        cfg_write(CFG_COS_HALF, 31'h4000_0000);
        cfg_write(CFG_TOL, 31'h2000_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hC000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h3FFF_FFFF);
        send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        drain();

        // random phases, one with a long receiver hold-off
        for (int ph = 0; ph < 12; ph++) begin
            random_cone();
            if (ph == 3) hold_off = 1'b1;
            for (int n = 0; n < 120; n++) begin
                if (hold_off && n == 40) hold_off = 1'b0;
                case ($urandom_range(0, 5))
                    0: send_point($urandom, $urandom, $urandom);
                    1: send_point(sb.cone.apex[0], sb.cone.apex[1], sb.cone.apex[2]);
                    2, 3: near_point();
                    default: send_point(rnd_coord(), rnd_coord(), rnd_coord());
                endcase
            end
            hold_off = 1'b0;
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("** cone_point_side_test_core: PASSED **");
        else
            $display("** cone_point_side_test_core: FAILED **");
        $finish;
    end

    // long receiver hold-off counted in cycles
    initial begin
        wait (hold_off);
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
    end
endmodule
